[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
// implication checked a fixed number of cycles later
`define ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(n) (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons, msg)
`endif

`endif

[rtl/core/vps_pkg.sv]
// ----------------------------------------------------------------------------
// Verlet particle step package
// Widths, reset values, operation codes and stage records of the core.
// ----------------------------------------------------------------------------
package vps_pkg;

    localparam int PARTICLES_DEF = 1024;

    localparam int IDX_W      = 10;
    localparam int POS_W      = 24;
    localparam int PIX_W      = 14;
    localparam int FRAC_W     = 8;
    localparam int FRAC16_W   = 16;
    localparam int MAG_W      = 23;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // one in Q1.16, base of the damping factor
    localparam logic [FRAC16_W:0] K_ONE = 17'h1_0000;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7F_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh80_0000;

    localparam logic [FRAC16_W-1:0]   DRAG_RST        = 16'd0;
    localparam logic [MAG_W-1:0]      ELASTICITY_RST  = 23'd2560;
    localparam logic [MAG_W-1:0]      CURSOR_SIZE_RST = 23'd5120;
    localparam logic [PIX_W-1:0]      VIEW_WIDTH_RST  = 14'd800;
    localparam logic [PIX_W-1:0]      VIEW_HEIGHT_RST = 14'd600;
    localparam logic [FRAC16_W-1:0]   STEP_TIME_RST   = 16'd1092;
    localparam logic signed [POS_W-1:0] ACCEL_X_RST   = 24'sd0;
    localparam logic signed [POS_W-1:0] ACCEL_Y_RST   = 24'sd251136;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_PLACE  = 2'd1,
        FUNC_PIN    = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAG        = 3'd0,
        CFG_ELASTICITY  = 3'd1,
        CFG_CURSOR_SIZE = 3'd2,
        CFG_VIEW_WIDTH  = 3'd3,
        CFG_VIEW_HEIGHT = 3'd4,
        CFG_STEP_TIME   = 3'd5,
        CFG_ACCEL_X     = 3'd6,
        CFG_ACCEL_Y     = 3'd7
    } t_cfg_idx;

    typedef logic signed [POS_W-1:0] t_pos;

    // one particle as stored in the state memory
    typedef struct packed {
        t_pos cur_x;
        t_pos cur_y;
        t_pos old_x;
        t_pos old_y;
        t_pos home_x;
        t_pos home_y;
        logic pinned;
    } t_entry;

    // accepted item
    typedef struct packed {
        t_func            func;
        logic [IDX_W-1:0] particle;
        logic             in_range;
        t_pos             mouse_x;
        t_pos             mouse_y;
        t_pos             mouse_prev_x;
        t_pos             mouse_prev_y;
        logic             left;
        logic             right;
        logic [PIX_W-1:0] place_x;
        logic [PIX_W-1:0] place_y;
    } t_item;

    // item after selection and drag, handed to the integrator
    typedef struct packed {
        t_func            func;
        logic [IDX_W-1:0] particle;
        logic             in_range;
        logic             sel;
        logic             brk;
        t_pos             cur_x;
        t_pos             cur_y;
        t_pos             old_x;
        t_pos             old_y;
        t_pos             home_x;
        t_pos             home_y;
        logic             pinned;
        logic [PIX_W-1:0] place_x;
        logic [PIX_W-1:0] place_y;
    } t_track;

    // write-back and result of the last stage
    typedef struct packed {
        logic             we;
        t_entry           entry;
        logic [IDX_W-1:0] particle;
        t_pos             pos_x;
        t_pos             pos_y;
        logic             sel;
        logic             brk;
    } t_result;

    function automatic logic signed [POS_W:0] sx25(input t_pos v);
        return $signed({v[POS_W-1], v});
    endfunction

    function automatic logic signed [POS_W+1:0] sx26(input t_pos v);
        return $signed({{2{v[POS_W-1]}}, v});
    endfunction

endpackage

[rtl/core/vps_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vps_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/vps_select.sv]
// ----------------------------------------------------------------------------
// Cursor selection and drag
// Three stages: distances and drag motion, squares, radius compare.
// ----------------------------------------------------------------------------
module vps_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  vps_pkg::t_item              i_item,
    input  vps_pkg::t_entry             i_entry,
    input  logic [vps_pkg::MAG_W-1:0]   i_elasticity,
    input  logic [vps_pkg::MAG_W-1:0]   i_cursor_size,
    input  logic [vps_pkg::IDX_W-1:0]   i_probe,
    output logic                        o_hit,
    output logic                        o_valid,
    output vps_pkg::t_track             o_track
);

    import vps_pkg::*;

    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * DIFF_W - 1;
    localparam int CSQ_W  = 2 * MAG_W;

    function automatic logic signed [DIFF_W-1:0] clamp_mag(
        input logic signed [DIFF_W-1:0] v,
        input logic signed [DIFF_W-1:0] lim
    );
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic t_pos sat_pos(input logic signed [DIFF_W:0] v);
        if (v > sx26(POS_MAX)) begin
            return POS_MAX;
        end else if (v < sx26(POS_MIN)) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // stage 1 -> 2
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_ex, w_ey, w_elas;
    logic                     r_s2_valid;
    t_item                    r_s2_item;
    t_entry                   r_s2_entry;
    logic signed [DIFF_W-1:0] r_s2_dx, r_s2_dy, r_s2_ex, r_s2_ey;

    // stage 2 -> 3
    logic signed [2*DIFF_W-1:0] w_dx2, w_dy2;
    logic                       r_s3_valid;
    t_item                      r_s3_item;
    t_entry                     r_s3_entry;
    logic [SQ_W-1:0]            r_s3_dx2, r_s3_dy2;
    t_pos                       r_s3_drag_x, r_s3_drag_y;

    // stage 3 -> 4
    logic [SQ_W:0]    w_d2;
    logic             w_update, w_sel, w_drag;
    logic [CSQ_W-1:0] r_csq;
    t_track           n_track, r_track;
    logic             r_s4_valid;

    assign w_elas = $signed({2'b00, i_elasticity});
    assign w_dx   = sx25(i_entry.cur_x) - sx25(i_item.mouse_x);
    assign w_dy   = sx25(i_entry.cur_y) - sx25(i_item.mouse_y);
    assign w_ex   = clamp_mag(sx25(i_item.mouse_x) - sx25(i_item.mouse_prev_x), w_elas);
    assign w_ey   = clamp_mag(sx25(i_item.mouse_y) - sx25(i_item.mouse_prev_y), w_elas);

    assign w_dx2 = r_s2_dx * r_s2_dx;
    assign w_dy2 = r_s2_dy * r_s2_dy;

    assign w_d2     = {1'b0, r_s3_dx2} + {1'b0, r_s3_dy2};
    assign w_update = r_s3_item.in_range && (r_s3_item.func == FUNC_UPDATE);
    assign w_sel    = w_update && (w_d2 < (SQ_W + 1)'(r_csq));
    assign w_drag   = w_sel && r_s3_item.left;

    always_comb begin
        n_track.func     = r_s3_item.func;
        n_track.particle = r_s3_item.particle;
        n_track.in_range = r_s3_item.in_range;
        n_track.sel      = w_sel;
        n_track.brk      = w_sel && r_s3_item.right;
        n_track.cur_x    = r_s3_entry.cur_x;
        n_track.cur_y    = r_s3_entry.cur_y;
        n_track.old_x    = w_drag ? r_s3_drag_x : r_s3_entry.old_x;
        n_track.old_y    = w_drag ? r_s3_drag_y : r_s3_entry.old_y;
        n_track.home_x   = r_s3_entry.home_x;
        n_track.home_y   = r_s3_entry.home_y;
        n_track.pinned   = r_s3_entry.pinned;
        n_track.place_x  = r_s3_item.place_x;
        n_track.place_y  = r_s3_item.place_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_csq       <= CSQ_W'(i_cursor_size) * CSQ_W'(i_cursor_size);
        r_s2_item   <= i_item;
        r_s2_entry  <= i_entry;
        r_s2_dx     <= w_dx;
        r_s2_dy     <= w_dy;
        r_s2_ex     <= w_ex;
        r_s2_ey     <= w_ey;
        r_s3_item   <= r_s2_item;
        r_s3_entry  <= r_s2_entry;
        r_s3_dx2    <= w_dx2[SQ_W-1:0];
        r_s3_dy2    <= w_dy2[SQ_W-1:0];
        r_s3_drag_x <= sat_pos(sx26(r_s2_entry.cur_x) - $signed({r_s2_ex[DIFF_W-1], r_s2_ex}));
        r_s3_drag_y <= sat_pos(sx26(r_s2_entry.cur_y) - $signed({r_s2_ey[DIFF_W-1], r_s2_ey}));
        r_track     <= n_track;
    end

    assign o_hit = (r_s2_valid && (r_s2_item.particle == i_probe))
                || (r_s3_valid && (r_s3_item.particle == i_probe))
                || (r_s4_valid && (r_track.particle == i_probe));

    assign o_valid = r_s4_valid;
    assign o_track = r_track;

endmodule

[rtl/core/vps_integrate.sv]
// ----------------------------------------------------------------------------
// Verlet integrator
// Velocity plus gravity, damping (both registered), rounding and view clamp.
// ----------------------------------------------------------------------------
module vps_integrate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  vps_pkg::t_track               i_track,
    input  logic [vps_pkg::FRAC16_W-1:0]  i_drag,
    input  logic [vps_pkg::PIX_W-1:0]     i_view_width,
    input  logic [vps_pkg::PIX_W-1:0]     i_view_height,
    input  logic [vps_pkg::FRAC16_W-1:0]  i_step_time,
    input  vps_pkg::t_pos                 i_accel_x,
    input  vps_pkg::t_pos                 i_accel_y,
    input  logic [vps_pkg::IDX_W-1:0]     i_probe,
    output logic                          o_hit,
    output logic                          o_valid,
    output vps_pkg::t_result              o_result
);

    import vps_pkg::*;

    localparam int DT2_W  = 2 * FRAC16_W;
    localparam int AP_W   = POS_W + DT2_W + 1;
    localparam int ACC_W  = POS_W + 1;
    localparam int VEL_W  = POS_W + 2;
    localparam int PRD_W  = VEL_W + FRAC16_W + 2;
    localparam int DEL_W  = PRD_W - FRAC16_W;
    localparam int NEW_W  = DEL_W + 1;

    localparam logic signed [AP_W-1:0]  HALF32 = AP_W'(64'h8000_0000);
    localparam logic signed [PRD_W-1:0] HALF16 = PRD_W'(32'h8000);

    function automatic logic signed [NEW_W-1:0] sx29(input t_pos v);
        return $signed({{(NEW_W - POS_W){v[POS_W-1]}}, v});
    endfunction

    function automatic t_pos clamp_view(
        input logic signed [NEW_W-1:0] v,
        input logic [PIX_W-1:0]        lim
    );
        if (v >= $signed({{(NEW_W - PIX_W - FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}})) begin
            return {{(POS_W - PIX_W - FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}};
        end else if (v < 0) begin
            return '0;
        end
        return v[POS_W-1:0];
    endfunction

    // gravity term, free running from the registers
    logic [DT2_W-1:0]        r_dt2;
    logic signed [AP_W-1:0]  r_axp, r_ayp, w_axr, w_ayr;
    logic signed [ACC_W-1:0] r_ax, r_ay;

    logic signed [VEL_W-1:0] w_vx, w_vy;
    logic                    r_s5_valid;
    t_track                  r_s5_track;
    logic signed [VEL_W-1:0] r_s5_vx, r_s5_vy;

    logic [FRAC16_W:0]       w_k;
    logic signed [PRD_W-1:0] w_px, w_py;
    logic                    r_s6_valid;
    t_track                  r_s6_track;
    logic signed [PRD_W-1:0] r_s6_px, r_s6_py;

    logic signed [PRD_W-1:0] w_rx, w_ry;
    logic [DEL_W-1:0]        w_dlx, w_dly;
    logic signed [NEW_W-1:0] w_nx, w_ny;
    t_pos                    w_place_x, w_place_y;
    t_result                 n_res;

    assign w_axr = r_axp + HALF32;
    assign w_ayr = r_ayp + HALF32;

    assign w_vx = sx26(i_track.cur_x) - sx26(i_track.old_x) + $signed({r_ax[ACC_W-1], r_ax});
    assign w_vy = sx26(i_track.cur_y) - sx26(i_track.old_y) + $signed({r_ay[ACC_W-1], r_ay});

    assign w_k  = K_ONE - {1'b0, i_drag};
    assign w_px = r_s5_vx * $signed({1'b0, w_k});
    assign w_py = r_s5_vy * $signed({1'b0, w_k});

    // round half up, then step from the current position
    assign w_rx  = r_s6_px + HALF16;
    assign w_ry  = r_s6_py + HALF16;
    assign w_dlx = w_rx[PRD_W-1:FRAC16_W];
    assign w_dly = w_ry[PRD_W-1:FRAC16_W];
    assign w_nx  = sx29(r_s6_track.cur_x) + $signed({w_dlx[DEL_W-1], w_dlx});
    assign w_ny  = sx29(r_s6_track.cur_y) + $signed({w_dly[DEL_W-1], w_dly});

    assign w_place_x = {{(POS_W - PIX_W - FRAC_W){1'b0}}, r_s6_track.place_x, {FRAC_W{1'b0}}};
    assign w_place_y = {{(POS_W - PIX_W - FRAC_W){1'b0}}, r_s6_track.place_y, {FRAC_W{1'b0}}};

    always_comb begin
        n_res.we           = 1'b0;
        n_res.entry.cur_x  = r_s6_track.cur_x;
        n_res.entry.cur_y  = r_s6_track.cur_y;
        n_res.entry.old_x  = r_s6_track.old_x;
        n_res.entry.old_y  = r_s6_track.old_y;
        n_res.entry.home_x = r_s6_track.home_x;
        n_res.entry.home_y = r_s6_track.home_y;
        n_res.entry.pinned = r_s6_track.pinned;
        n_res.particle     = r_s6_track.particle;
        n_res.pos_x        = r_s6_track.cur_x;
        n_res.pos_y        = r_s6_track.cur_y;
        n_res.sel          = r_s6_track.sel;
        n_res.brk          = r_s6_track.brk;
        if (!r_s6_track.in_range) begin
            n_res.pos_x = '0;
            n_res.pos_y = '0;
        end else begin
            case (r_s6_track.func)
                FUNC_PLACE: begin
                    n_res.we           = 1'b1;
                    n_res.entry.cur_x  = w_place_x;
                    n_res.entry.cur_y  = w_place_y;
                    n_res.entry.old_x  = w_place_x;
                    n_res.entry.old_y  = w_place_y;
                    n_res.entry.home_x = w_place_x;
                    n_res.entry.home_y = w_place_y;
                    n_res.entry.pinned = 1'b0;
                    n_res.pos_x        = w_place_x;
                    n_res.pos_y        = w_place_y;
                end
                FUNC_PIN: begin
                    n_res.we           = 1'b1;
                    n_res.entry.pinned = 1'b1;
                end
                FUNC_UPDATE: begin
                    n_res.we = 1'b1;
                    if (r_s6_track.pinned) begin
                        // snap home, keep the (possibly dragged) previous position
                        n_res.entry.cur_x = r_s6_track.home_x;
                        n_res.entry.cur_y = r_s6_track.home_y;
                    end else begin
                        n_res.entry.old_x = r_s6_track.cur_x;
                        n_res.entry.old_y = r_s6_track.cur_y;
                        n_res.entry.cur_x = clamp_view(w_nx, i_view_width);
                        n_res.entry.cur_y = clamp_view(w_ny, i_view_height);
                    end
                    n_res.pos_x = n_res.entry.cur_x;
                    n_res.pos_y = n_res.entry.cur_y;
                end
                default: begin
                end
            endcase
        end
        n_res.we = n_res.we && r_s6_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            r_s5_valid <= i_valid;
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt2      <= DT2_W'(i_step_time) * DT2_W'(i_step_time);
        r_axp      <= i_accel_x * $signed({1'b0, r_dt2});
        r_ayp      <= i_accel_y * $signed({1'b0, r_dt2});
        r_ax       <= w_axr[AP_W-1:DT2_W];
        r_ay       <= w_ayr[AP_W-1:DT2_W];
        r_s5_track <= i_track;
        r_s5_vx    <= w_vx;
        r_s5_vy    <= w_vy;
        r_s6_track <= r_s5_track;
        r_s6_px    <= w_px;
        r_s6_py    <= w_py;
    end

    assign o_hit = (r_s5_valid && (r_s5_track.particle == i_probe))
                || (r_s6_valid && (r_s6_track.particle == i_probe));

    assign o_valid  = r_s6_valid;
    assign o_result = n_res;

endmodule

[rtl/core/verlet_particle_step_core.sv]
// ----------------------------------------------------------------------------
// Verlet particle step core
// Takes one item per clock while busy is low: place, pin or update a particle.
// Each item gives one result through the stage and result registers, shown
// for one cycle with o_done; the receiver cannot stall, so the result must be
// taken in that cycle. All particle state sits in one memory read at acceptance
// and written back from the last integrator stage, so busy rises for an item
// whose particle still has an earlier item in that read-modify-write pipeline:
// such an item waits until the earlier one is written back, while items on
// distinct particles flow at one per clock. There is no clearing pass after
// reset: place clears the pin flag, and a particle must be placed before it is
// pinned or updated. Write registers only while no item is in flight; the
// derived terms (step time squared, scaled gravity, squared cursor radius) are
// registered and settle ahead of any item that needs them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module verlet_particle_step_core #(
    parameter int PARTICLES = vps_pkg::PARTICLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item port
    input  logic                              start,
    output logic                              busy,
    input  logic [vps_pkg::FUNC_W-1:0]        i_func,
    input  logic [vps_pkg::IDX_W-1:0]         i_particle,
    input  logic signed [vps_pkg::POS_W-1:0]  i_mouse_x,
    input  logic signed [vps_pkg::POS_W-1:0]  i_mouse_y,
    input  logic signed [vps_pkg::POS_W-1:0]  i_mouse_prev_x,
    input  logic signed [vps_pkg::POS_W-1:0]  i_mouse_prev_y,
    input  logic                              i_left_button,
    input  logic                              i_right_button,
    input  logic [vps_pkg::PIX_W-1:0]         i_place_x,
    input  logic [vps_pkg::PIX_W-1:0]         i_place_y,
    // register write port
    input  logic                              i_cfg_we,
    input  logic [vps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // result port
    output logic                              o_done,
    output logic [vps_pkg::IDX_W-1:0]         o_out_particle,
    output logic signed [vps_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [vps_pkg::POS_W-1:0]  o_pos_y,
    output logic                              o_selected,
    output logic                              o_break_sticks
);

    import vps_pkg::*;

    localparam int ADDR_W   = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int DONE_LAT = 7;

    // registers
    logic [FRAC16_W-1:0] r_drag;
    logic [MAG_W-1:0]    r_elasticity;
    logic [MAG_W-1:0]    r_cursor_size;
    logic [PIX_W-1:0]    r_view_width;
    logic [PIX_W-1:0]    r_view_height;
    logic [FRAC16_W-1:0] r_step_time;
    t_pos                r_accel_x;
    t_pos                r_accel_y;

    logic        w_accept;
    logic [31:0] w_ridx32, w_widx32;
    t_item       n_item, r_s1_item;
    logic        r_s1_valid;
    t_entry      w_rdata;

    logic    w_sel_hit, w_int_hit;
    logic    w_sel_valid, w_int_valid;
    t_track  w_track;
    t_result w_res;

    logic                r_done;
    logic [IDX_W-1:0]    r_out_particle;
    t_pos                r_pos_x, r_pos_y;
    logic                r_selected, r_break_sticks;

    // hold off an item whose particle is still in the pipeline
    assign busy     = (r_s1_valid && (r_s1_item.particle == i_particle)) || w_sel_hit
                   || w_int_hit;
    assign w_accept = start && !busy;

    assign w_ridx32 = 32'(i_particle);
    assign w_widx32 = 32'(w_res.particle);

    always_comb begin
        n_item.func         = t_func'(i_func);
        n_item.particle     = i_particle;
        n_item.in_range     = w_ridx32 < 32'(PARTICLES);
        n_item.mouse_x      = i_mouse_x;
        n_item.mouse_y      = i_mouse_y;
        n_item.mouse_prev_x = i_mouse_prev_x;
        n_item.mouse_prev_y = i_mouse_prev_y;
        n_item.left         = i_left_button;
        n_item.right        = i_right_button;
        n_item.place_x      = i_place_x;
        n_item.place_y      = i_place_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag        <= DRAG_RST;
            r_elasticity  <= ELASTICITY_RST;
            r_cursor_size <= CURSOR_SIZE_RST;
            r_view_width  <= VIEW_WIDTH_RST;
            r_view_height <= VIEW_HEIGHT_RST;
            r_step_time   <= STEP_TIME_RST;
            r_accel_x     <= ACCEL_X_RST;
            r_accel_y     <= ACCEL_Y_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DRAG:        r_drag        <= i_cfg_data[FRAC16_W-1:0];
                CFG_ELASTICITY:  r_elasticity  <= i_cfg_data[MAG_W-1:0];
                CFG_CURSOR_SIZE: r_cursor_size <= i_cfg_data[MAG_W-1:0];
                CFG_VIEW_WIDTH:  r_view_width  <= i_cfg_data[PIX_W-1:0];
                CFG_VIEW_HEIGHT: r_view_height <= i_cfg_data[PIX_W-1:0];
                CFG_STEP_TIME:   r_step_time   <= i_cfg_data[FRAC16_W-1:0];
                CFG_ACCEL_X:     r_accel_x     <= i_cfg_data[POS_W-1:0];
                CFG_ACCEL_Y:     r_accel_y     <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1: the memory read is in flight alongside the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= n_item;
        end
    end

    vps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (PARTICLES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_res.we),
        .i_waddr (w_widx32[ADDR_W-1:0]),
        .i_wdata (w_res.entry),
        .i_re    (w_accept),
        .i_raddr (w_ridx32[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // stages 2 to 4: selection test and drag
    vps_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .i_item        (r_s1_item),
        .i_entry       (w_rdata),
        .i_elasticity  (r_elasticity),
        .i_cursor_size (r_cursor_size),
        .i_probe       (i_particle),
        .o_hit         (w_sel_hit),
        .o_valid       (w_sel_valid),
        .o_track       (w_track)
    );

    // stages 5 and 6: integration, clamp, write-back
    vps_integrate u_integrate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_sel_valid),
        .i_track       (w_track),
        .i_drag        (r_drag),
        .i_view_width  (r_view_width),
        .i_view_height (r_view_height),
        .i_step_time   (r_step_time),
        .i_accel_x     (r_accel_x),
        .i_accel_y     (r_accel_y),
        .i_probe       (i_particle),
        .o_hit         (w_int_hit),
        .o_valid       (w_int_valid),
        .o_result      (w_res)
    );

    // result register: one cycle per item, the receiver has no say
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_int_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_int_valid) begin
            r_out_particle <= w_res.particle;
            r_pos_x        <= w_res.pos_x;
            r_pos_y        <= w_res.pos_y;
            r_selected     <= w_res.sel;
            r_break_sticks <= w_res.brk;
        end
    end

    assign o_done         = r_done;
    assign o_out_particle = r_out_particle;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_selected     = r_selected;
    assign o_break_sticks = r_break_sticks;

    `ASSERT_AFTER(a_result_latency, i_clk, i_rst_n, w_accept, DONE_LAT, r_done, "accepted item gave no result on time")
    `ASSERT_NEXT(a_same_particle_held, i_clk, i_rst_n, w_accept, busy || (i_particle != $past(i_particle)), "back-to-back item on one particle not held off")
    `ASSERT_IMPLIES(a_break_needs_select, i_clk, i_rst_n, r_done && r_break_sticks, r_selected, "sticks break without selection")

endmodule
